// File: hw/rtl/moalu_pkg.sv
// Shared types, operation and fault codes, and index helper for the memory operand ALU.
package moalu_pkg;

    localparam int WORDS   = 128;
    localparam int IDX_W   = $clog2(WORDS);
    localparam int IDX_FW  = 7;
    localparam int Q_W     = 32;
    localparam int OP_W    = 3;
    localparam int FAULT_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_OVF  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_DIVZ = 2'd2;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic [IDX_FW-1:0]        dest_index;
        logic                     src_is_memory;
        logic [IDX_FW-1:0]        src_index;
        logic signed [Q_W-1:0]    immediate;
    } req_t;

    typedef struct packed {
        logic [IDX_FW-1:0]        written_index;
        logic signed [Q_W-1:0]    written_value;
        logic [FAULT_W-1:0]       fault;
    } res_t;

    // Index field reduced modulo WORDS by conditional subtraction of WORDS << k.
    function automatic logic [IDX_W-1:0] word_index(input logic [IDX_FW-1:0] raw);
        logic [IDX_FW-1:0] v;
        v = raw;
        for (int k = IDX_FW - 1; k >= 0; k--) begin
            if (int'(v) >= (WORDS << k)) begin
                v = v - IDX_FW'(WORDS << k);
            end
        end
        return IDX_W'(v);
    endfunction

endpackage

// File: hw/rtl/moalu_ram.sv
// Word memory: one write port, two read ports with registered read data.
module moalu_ram #(
    parameter int DEPTH = 128,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] ra_addr,
    input  logic [AW-1:0] rb_addr,
    output logic [DW-1:0] ra_data,
    output logic [DW-1:0] rb_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            ra_data <= mem[ra_addr];
            rb_data <= mem[rb_addr];
        end
    end

endmodule

// File: hw/rtl/moalu_div.sv
// Iterative Q16.16 divider, one quotient bit a cycle, with saturation and divide-by-zero.
module moalu_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic signed [moalu_pkg::Q_W-1:0]  dividend,
    input  logic signed [moalu_pkg::Q_W-1:0]  divisor,
    output logic                              done,
    output logic signed [moalu_pkg::Q_W-1:0]  quotient,
    output logic [moalu_pkg::FAULT_W-1:0]     fault
);
    import moalu_pkg::*;

    localparam int HALF  = Q_W / 2;
    localparam int CNT_W = $clog2(Q_W);

    typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN, DV_DONE} dv_state_t;
    typedef enum logic [1:0] {K_NORM, K_ZERO, K_OVF} kind_t;

    dv_state_t        state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [Q_W-1:0]   a_reg, a_next;
    logic [Q_W-1:0]   b_reg, b_next;
    logic             neg_reg, neg_next;
    logic             dneg_reg, dneg_next;
    logic [Q_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [Q_W:0]     trial;
    logic             q_bit;

    assign trial = {rem_reg, sh_reg[Q_W-1]};
    assign q_bit = (trial >= {1'b0, b_reg});

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        dneg_next  = dneg_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (go)
                begin
                    a_next     = dividend[Q_W-1] ? (~dividend + 1'b1) : dividend;
                    b_next     = divisor[Q_W-1] ? (~divisor + 1'b1) : divisor;
                    dneg_next  = dividend[Q_W-1];
                    neg_next   = dividend[Q_W-1] ^ divisor[Q_W-1];
                    state_next = DV_CHECK;
                end
            end
            DV_CHECK:
            begin
                kind_next = K_NORM;
                rem_next  = {{HALF{1'b0}}, a_reg[Q_W-1:HALF]};
                sh_next   = {a_reg[HALF-1:0], {HALF{1'b0}}};
                q_next    = '0;
                cnt_next  = '0;
                if (b_reg == '0)
                begin
                    kind_next  = K_ZERO;
                    state_next = DV_DONE;
                end
                else if ({{HALF{1'b0}}, a_reg[Q_W-1:HALF]} >= b_reg)
                begin
                    // quotient would need more than 32 bits
                    kind_next  = K_OVF;
                    state_next = DV_DONE;
                end
                else
                begin
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next = q_bit ? Q_W'(trial - {1'b0, b_reg}) : trial[Q_W-1:0];
                sh_next  = {sh_reg[Q_W-2:0], 1'b0};
                q_next   = {q_reg[Q_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            kind_reg  <= K_NORM;
            a_reg     <= '0;
            b_reg     <= '0;
            neg_reg   <= 1'b0;
            dneg_reg  <= 1'b0;
            rem_reg   <= '0;
            sh_reg    <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            neg_reg   <= neg_next;
            dneg_reg  <= dneg_next;
            rem_reg   <= rem_next;
            sh_reg    <= sh_next;
            q_reg     <= q_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign done = (state_reg == DV_DONE);

    always_comb
    begin
        quotient = q_reg;
        fault    = FAULT_NONE;
        case (kind_reg)
            K_ZERO:
            begin
                fault = FAULT_DIVZ;
                if (a_reg == '0)
                begin
                    quotient = '0;
                end
                else
                begin
                    quotient = dneg_reg ? Q_MIN : Q_MAX;
                end
            end
            K_OVF:
            begin
                fault    = FAULT_OVF;
                quotient = neg_reg ? Q_MIN : Q_MAX;
            end
            default:
            begin
                if (!neg_reg)
                begin
                    if (q_reg[Q_W-1])
                    begin
                        fault    = FAULT_OVF;
                        quotient = Q_MAX;
                    end
                end
                else if (q_reg > Q_MIN)
                begin
                    fault    = FAULT_OVF;
                    quotient = Q_MIN;
                end
                else
                begin
                    quotient = ~q_reg + 1'b1;
                end
            end
        endcase
    end

endmodule

// File: hw/rtl/memory_operand_alu.sv
// After accept, load, move, add, subtract and unused codes finish in ST_OPERAND, multiply
// in ST_MUL, and divide in ST_DIV on divider done, which skips the bit loop on a zero
// divisor or a quotient past 32 bits. One item at a time: the next item is accepted at the
// earliest at the edge that takes the result.
// Results are strobed on done for one cycle; the receiver cannot stall.
// After reset the word memory is cleared, one word a cycle, with busy high until all WORDS (128) are zero.
module memory_operand_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  moalu_pkg::req_t   req,
    output logic              done,
    output moalu_pkg::res_t   result
);
    import moalu_pkg::*;

    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(WORDS - 1);
    localparam int HALF_SH = Q_W / 2;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_OPERAND, ST_MUL, ST_DIV} state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_reg, clr_next;
    req_t                   req_reg, req_next;
    logic [IDX_W-1:0]       di_reg, di_next;
    logic signed [2*Q_W-1:0] prod_reg, prod_next;
    logic                   done_reg, done_next;
    res_t                   result_reg, result_next;

    logic [Q_W-1:0]         ra_data, rb_data;
    logic signed [Q_W-1:0]  d, s;
    logic [Q_W:0]           add_sum, sub_diff;
    logic signed [2*Q_W-1:0] mul_round;
    logic                   mul_fits;
    logic                   accept;
    logic                   fin;
    logic [Q_W-1:0]         fin_value;
    logic [FAULT_W-1:0]     fin_fault;
    logic                   div_go, div_done;
    logic signed [Q_W-1:0]  div_q;
    logic [FAULT_W-1:0]     div_fault;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [Q_W-1:0]         ram_wdata;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign d = ra_data;
    assign s = req_reg.src_is_memory ? rb_data : req_reg.immediate;

    assign add_sum   = {d[Q_W-1], d} + {s[Q_W-1], s};
    assign sub_diff  = {d[Q_W-1], d} - {s[Q_W-1], s};
    assign prod_next = d * s;
    assign mul_round = prod_reg + 64'sd32768;
    assign mul_fits  = (mul_round[2*Q_W-1:Q_W+HALF_SH-1] == '0)
                    || (mul_round[2*Q_W-1:Q_W+HALF_SH-1] == '1);

    assign div_go = (state_reg == ST_OPERAND) && (req_reg.req_type == OP_DIV);

    moalu_ram #(
        .DEPTH (WORDS),
        .DW    (Q_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (accept),
        .ra_addr (word_index(req.dest_index)),
        .rb_addr (word_index(req.src_index)),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    moalu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (d),
        .divisor  (s),
        .done     (div_done),
        .quotient (div_q),
        .fault    (div_fault)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        req_next   = req_reg;
        di_next    = di_reg;
        fin        = 1'b0;
        fin_value  = d;
        fin_fault  = FAULT_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    di_next    = word_index(req.dest_index);
                    state_next = ST_OPERAND;
                end
            end
            ST_OPERAND:
            begin
                state_next = ST_IDLE;
                fin        = 1'b1;
                unique case (req_reg.req_type)
                    OP_LOAD:
                    begin
                        fin_value = req_reg.immediate;
                    end
                    OP_MOVE:
                    begin
                        fin_value = s;
                    end
                    OP_ADD:
                    begin
                        if (add_sum[Q_W] != add_sum[Q_W-1])
                        begin
                            fin_value = add_sum[Q_W] ? Q_MIN : Q_MAX;
                            fin_fault = FAULT_OVF;
                        end
                        else
                        begin
                            fin_value = add_sum[Q_W-1:0];
                        end
                    end
                    OP_SUB:
                    begin
                        if (sub_diff[Q_W] != sub_diff[Q_W-1])
                        begin
                            fin_value = sub_diff[Q_W] ? Q_MIN : Q_MAX;
                            fin_fault = FAULT_OVF;
                        end
                        else
                        begin
                            fin_value = sub_diff[Q_W-1:0];
                        end
                    end
                    OP_MUL:
                    begin
                        fin        = 1'b0;
                        state_next = ST_MUL;
                    end
                    OP_DIV:
                    begin
                        fin        = 1'b0;
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        // unused codes rewrite the word unchanged
                        fin_value = d;
                    end
                endcase
            end
            ST_MUL:
            begin
                // arithmetic shift of the biased product is round half up
                fin        = 1'b1;
                state_next = ST_IDLE;
                if (mul_fits)
                begin
                    fin_value = mul_round[Q_W+HALF_SH-1:HALF_SH];
                end
                else
                begin
                    fin_value = mul_round[2*Q_W-1] ? Q_MIN : Q_MAX;
                    fin_fault = FAULT_OVF;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    fin        = 1'b1;
                    fin_value  = div_q;
                    fin_fault  = div_fault;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done_next                 = fin;
        result_next.written_index = IDX_FW'(di_reg);
        result_next.written_value = fin_value;
        result_next.fault         = fin_fault;
    end

    assign ram_we    = fin || (state_reg == ST_CLEAR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : di_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : fin_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            req_reg    <= '0;
            di_reg     <= '0;
            prod_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            req_reg    <= req_next;
            di_reg     <= di_next;
            prod_reg   <= prod_next;
            done_reg   <= done_next;
            if (fin)
            begin
                result_reg <= result_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
